### rtl/rbpi_pkg.sv
// ----------------------------------------------------------------------------
// rbpi_pkg
// Shared widths, constants, codes and the microcode table of the reservation
// bandwidth PI controller.
// ----------------------------------------------------------------------------
package rbpi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int BW_W      = 17;
   localparam int CLAMP_W   = 2;
   localparam int DIFF_W    = WORD_W + 1;
   localparam int PROD_W    = WORD_W + DIFF_W;
   localparam int TERM_W    = PROD_W - FRAC_BITS;
   localparam int ACC_W     = TERM_W + 2;
   localparam int DIV_W     = 2 * FRAC_BITS + 1;
   localparam int CNT_W     = $clog2(DIV_W + 1);

   localparam int REQ_TDATA_W = ((WORD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((BW_W + CLAMP_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [DIV_W-1:0]  ONE_SQ       = {1'b1, {(2 * FRAC_BITS){1'b0}}};
   localparam logic [BW_W-1:0]   MIN_BW       = BW_W'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic [BW_W-1:0]   MAX_BW_RESET = BW_W'(1 << FRAC_BITS);
   localparam logic [WORD_W-1:0] DRIVE_ONE    = WORD_W'(1 << FRAC_BITS);
   localparam logic [WORD_W-1:0] DRIVE_MAX    = {1'b0, {(WORD_W - 1){1'b1}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GAIN_A_NEG = 3'd0,
      REG_GAIN_B_NEG = 3'd1,
      REG_GAIN_A_POS = 3'd2,
      REG_GAIN_B_POS = 3'd3,
      REG_TARGET     = 3'd4,
      REG_MAX_BW     = 3'd5
   } reg_index_type;

   typedef enum logic [CLAMP_W-1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_MAX  = 2'd1,
      CLAMP_MIN  = 2'd2
   } clamp_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] gain_a_negative;
      logic signed [WORD_W-1:0] gain_b_negative;
      logic signed [WORD_W-1:0] gain_a_positive;
      logic signed [WORD_W-1:0] gain_b_positive;
      logic signed [WORD_W-1:0] target_error;
      logic        [BW_W-1:0]   max_bandwidth;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_A,
      OP_MUL_B,
      OP_SUM,
      OP_SAT,
      OP_DIV_DRV,
      OP_CLAMP,
      OP_DIV_BW,
      OP_SET_DRIVE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DRIVE_NONPOS,
      COND_DIV_BUSY,
      COND_NO_CLAMP,
      COND_OUT_FULL
   } cond_type;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type STEP_LOAD      = 4'd0;
   localparam pc_type STEP_MUL_A     = 4'd1;
   localparam pc_type STEP_MUL_B     = 4'd2;
   localparam pc_type STEP_SUM       = 4'd3;
   localparam pc_type STEP_SAT       = 4'd4;
   localparam pc_type STEP_DIV_DRV   = 4'd5;
   localparam pc_type STEP_WAIT_DRV  = 4'd6;
   localparam pc_type STEP_CLAMP     = 4'd7;
   localparam pc_type STEP_DIV_BW    = 4'd8;
   localparam pc_type STEP_WAIT_BW   = 4'd9;
   localparam pc_type STEP_SET_DRIVE = 4'd10;
   localparam pc_type STEP_EMIT      = 4'd11;
   localparam pc_type STEP_RETURN    = 4'd12;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctl_type;

   typedef struct packed {
      logic div_busy;
      logic drive_nonpos;
      logic no_clamp;
   } dp_flags_type;

   typedef struct packed {
      logic         no_req;
      logic         out_full;
      dp_flags_type dp;
   } seq_flags_type;

   function automatic ctl_type microcode(input pc_type pc);
      ctl_type w;
      unique case (pc)
         STEP_LOAD:      w = '{op: OP_LOAD,      cond: COND_NO_REQ,       target: STEP_LOAD};
         STEP_MUL_A:     w = '{op: OP_MUL_A,     cond: COND_NEVER,        target: STEP_LOAD};
         STEP_MUL_B:     w = '{op: OP_MUL_B,     cond: COND_NEVER,        target: STEP_LOAD};
         STEP_SUM:       w = '{op: OP_SUM,       cond: COND_NEVER,        target: STEP_LOAD};
         STEP_SAT:       w = '{op: OP_SAT,       cond: COND_NEVER,        target: STEP_LOAD};
         STEP_DIV_DRV:   w = '{op: OP_DIV_DRV,   cond: COND_DRIVE_NONPOS, target: STEP_CLAMP};
         STEP_WAIT_DRV:  w = '{op: OP_NOP,       cond: COND_DIV_BUSY,     target: STEP_WAIT_DRV};
         STEP_CLAMP:     w = '{op: OP_CLAMP,     cond: COND_NEVER,        target: STEP_LOAD};
         STEP_DIV_BW:    w = '{op: OP_DIV_BW,    cond: COND_NO_CLAMP,     target: STEP_EMIT};
         STEP_WAIT_BW:   w = '{op: OP_NOP,       cond: COND_DIV_BUSY,     target: STEP_WAIT_BW};
         STEP_SET_DRIVE: w = '{op: OP_SET_DRIVE, cond: COND_NEVER,        target: STEP_LOAD};
         STEP_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_FULL,     target: STEP_EMIT};
         STEP_RETURN:    w = '{op: OP_NOP,       cond: COND_ALWAYS,       target: STEP_LOAD};
         default:        w = '{op: OP_NOP,       cond: COND_ALWAYS,       target: STEP_LOAD};
      endcase
      return w;
   endfunction

endpackage

### rtl/rbpi_div.sv
// ----------------------------------------------------------------------------
// rbpi_div
// Radix-2 restoring divider computing 2^(2F) / divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module rbpi_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rbpi_pkg::WORD_W-1:0] divisor,
   output logic                        busy,
   output logic [rbpi_pkg::DIV_W-1:0]  quotient
);
   import rbpi_pkg::*;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] divisor_ff, divisor_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [WORD_W:0]   rem_sh;
   logic [WORD_W:0]   diff;

   assign rem_sh = {rem_ff, quot_ff[DIV_W-1]};
   assign diff   = rem_sh - {1'b0, divisor_ff};

   always_comb begin
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      if (start) begin
         cnt_in     = CNT_W'(DIV_W);
         divisor_in = divisor;
         rem_in     = '0;
         quot_in    = ONE_SQ;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (!diff[WORD_W]) begin
            rem_in  = diff[WORD_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[WORD_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quot_ff;

endmodule

### rtl/rbpi_datapath.sv
// ----------------------------------------------------------------------------
// rbpi_datapath
// Registers, shared multiplier, saturation and clamp logic of the controller,
// driven one micro-op per cycle by the sequencer.
// ----------------------------------------------------------------------------
module rbpi_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rbpi_pkg::op_type             op,
   input  logic                         load_en,
   input  logic                         emit_en,
   input  logic [rbpi_pkg::WORD_W-1:0]  scheduling_error,
   input  rbpi_pkg::cfg_type            cfg,
   output logic [rbpi_pkg::BW_W-1:0]    bandwidth,
   output rbpi_pkg::clamp_type          clamp_status,
   output rbpi_pkg::dp_flags_type       flags
);
   import rbpi_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(DRIVE_MAX);
   localparam logic signed [ACC_W-1:0] ACC_LO = ~ACC_HI;

   logic signed [WORD_W-1:0] e_ff, e_in;
   logic signed [DIFF_W-1:0] dnow_ff, dnow_in;
   logic signed [DIFF_W-1:0] dprev_ff, dprev_in;
   logic signed [TERM_W-1:0] pa_ff, pa_in;
   logic signed [TERM_W-1:0] pb_ff, pb_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [WORD_W-1:0] drive_ff, drive_in;
   logic        [BW_W-1:0]   bw_ff, bw_in;
   clamp_type                status_ff, status_in;
   logic signed [WORD_W-1:0] prev_drive_ff, prev_drive_in;
   logic signed [WORD_W-1:0] prev_error_ff, prev_error_in;

   logic signed [WORD_W-1:0] mul_x;
   logic signed [DIFF_W-1:0] mul_y;
   logic signed [PROD_W-1:0] prod;
   logic                     neg_err;
   logic                     drive_pos;
   logic                     drive_zero;
   logic                     drive_neg;
   logic                     div_start;
   logic        [WORD_W-1:0] div_divisor;
   logic                     div_busy;
   logic        [DIV_W-1:0]  quot;
   logic        [BW_W-1:0]   clamp_bw;
   clamp_type                clamp_st;
   logic signed [WORD_W-1:0] quot_sat;
   logic signed [ACC_W-1:0]  pd_ext;

   assign neg_err    = e_ff[WORD_W-1];
   assign drive_zero = (drive_ff == '0);
   assign drive_neg  = drive_ff[WORD_W-1];
   assign drive_pos  = !drive_neg && !drive_zero;

   assign mul_x = (op == OP_MUL_A) ? (neg_err ? cfg.gain_a_negative : cfg.gain_a_positive)
                                   : (neg_err ? cfg.gain_b_negative : cfg.gain_b_positive);
   assign mul_y = (op == OP_MUL_A) ? dnow_ff : dprev_ff;
   assign prod  = mul_x * mul_y;

   assign pd_ext = ACC_W'(prev_drive_ff);

   assign div_start   = ((op == OP_DIV_DRV) && drive_pos)
                     || ((op == OP_DIV_BW) && (status_ff != CLAMP_NONE));
   assign div_divisor = (op == OP_DIV_DRV) ? drive_ff : WORD_W'(bw_ff);

   rbpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign quot_sat = ({{WORD_W{1'b0}}, quot} > {{DIV_W{1'b0}}, DRIVE_MAX})
                   ? DRIVE_MAX : WORD_W'(quot);

   // max clamp first, min clamp overrides
   always_comb begin
      clamp_bw = '0;
      clamp_st = CLAMP_NONE;
      if (drive_zero || (drive_pos && (quot > DIV_W'(cfg.max_bandwidth)))) begin
         clamp_bw = cfg.max_bandwidth;
         clamp_st = CLAMP_MAX;
      end else if (drive_pos) begin
         clamp_bw = BW_W'(quot);
      end
      if (drive_neg || (clamp_bw < MIN_BW)) begin
         clamp_bw = MIN_BW;
         clamp_st = CLAMP_MIN;
      end
   end

   always_comb begin
      e_in          = e_ff;
      dnow_in       = dnow_ff;
      dprev_in      = dprev_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      acc_in        = acc_ff;
      drive_in      = drive_ff;
      bw_in         = bw_ff;
      status_in     = status_ff;
      prev_drive_in = prev_drive_ff;
      prev_error_in = prev_error_ff;
      case (op)
         OP_LOAD: begin
            if (load_en) begin
               e_in     = scheduling_error;
               dnow_in  = DIFF_W'($signed(scheduling_error)) - DIFF_W'(cfg.target_error);
               dprev_in = DIFF_W'(prev_error_ff) - DIFF_W'(cfg.target_error);
            end
         end
         OP_MUL_A:     pa_in = prod[PROD_W-1:FRAC_BITS];
         OP_MUL_B:     pb_in = prod[PROD_W-1:FRAC_BITS];
         OP_SUM:       acc_in = pd_ext - ACC_W'(pa_ff) - ACC_W'(pb_ff);
         OP_SAT: begin
            if (acc_ff > ACC_HI) begin
               drive_in = DRIVE_MAX;
            end else if (acc_ff < ACC_LO) begin
               drive_in = ~DRIVE_MAX;
            end else begin
               drive_in = WORD_W'(acc_ff);
            end
         end
         OP_CLAMP: begin
            bw_in     = clamp_bw;
            status_in = clamp_st;
         end
         OP_SET_DRIVE: drive_in = quot_sat;
         OP_EMIT: begin
            if (emit_en) begin
               prev_drive_in = drive_ff;
               prev_error_in = e_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_drive_ff <= DRIVE_ONE;
         prev_error_ff <= '0;
      end else begin
         prev_drive_ff <= prev_drive_in;
         prev_error_ff <= prev_error_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff      <= e_in;
      dnow_ff   <= dnow_in;
      dprev_ff  <= dprev_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      acc_ff    <= acc_in;
      drive_ff  <= drive_in;
      bw_ff     <= bw_in;
      status_ff <= status_in;
   end

   assign bandwidth          = bw_ff;
   assign clamp_status       = status_ff;
   assign flags.div_busy     = div_busy;
   assign flags.drive_nonpos = !drive_pos;
   assign flags.no_clamp     = (status_ff == CLAMP_NONE);

`ifndef NO_ASSERTIONS
   a_bw_above_min: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> (bw_ff >= MIN_BW))
      else $error("bandwidth below minimum at emit");

   a_unclamped_below_max: assert property (@(posedge clock) disable iff (reset)
      (emit_en && (status_ff == CLAMP_NONE)) |-> (bw_ff <= cfg.max_bandwidth))
      else $error("unclamped bandwidth above maximum");

   a_unclamped_drive_pos: assert property (@(posedge clock) disable iff (reset)
      (emit_en && (status_ff == CLAMP_NONE)) |-> drive_pos)
      else $error("unclamped result with non-positive drive");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");
`endif

endmodule

### rtl/rbpi_seq.sv
// ----------------------------------------------------------------------------
// rbpi_seq
// Microcode sequencer: step counter, control word lookup and conditional
// jumps.
// ----------------------------------------------------------------------------
module rbpi_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  rbpi_pkg::seq_flags_type flags,
   output rbpi_pkg::op_type        op
);
   import rbpi_pkg::*;

   pc_type  pc_ff, pc_in;
   ctl_type word;
   logic    jump;

   assign word = microcode(pc_ff);

   always_comb begin
      unique case (word.cond)
         COND_NEVER:        jump = 1'b0;
         COND_ALWAYS:       jump = 1'b1;
         COND_NO_REQ:       jump = flags.no_req;
         COND_DRIVE_NONPOS: jump = flags.dp.drive_nonpos;
         COND_DIV_BUSY:     jump = flags.dp.div_busy;
         COND_NO_CLAMP:     jump = flags.dp.no_clamp;
         COND_OUT_FULL:     jump = flags.out_full;
         default:           jump = 1'b1;
      endcase
      pc_in = jump ? word.target : pc_ff + PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = word.op;

`ifndef NO_ASSERTIONS
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_RETURN)
      else $error("step counter left the program");

   a_load_after_return: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_RETURN) |=> (pc_ff == STEP_LOAD))
      else $error("program did not return to load step");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == STEP_WAIT_DRV) && flags.dp.div_busy) |=> (pc_ff == STEP_WAIT_DRV))
      else $error("left divider wait while busy");
`endif

endmodule

### rtl/reservation_bandwidth_pi_controller.sv
// ----------------------------------------------------------------------------
// reservation_bandwidth_pi_controller
// Incremental PI controller turning scheduling-error samples into a clamped
// reservation bandwidth.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each sample runs through a 13-step
// microprogram on a shared 33-step radix-2 divider. Only bandwidth =
// 2^32/drive runs when the drive is positive and no clamp applies, only
// drive = 2^32/bandwidth runs when the drive is not positive, and both
// reciprocals run when the drive is positive and a clamp applies. A full
// output register holds the program at its emit step. After the result is
// loaded into the output register, the program passes its return step and
// its load step before the next sample is accepted.
// Configuration writes are taken at any cycle; csr_ready is always high.
module reservation_bandwidth_pi_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] scheduling_error
   input  logic [rbpi_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [16:0] bandwidth, [18:17] clamp_status, rest zero
   output logic [rbpi_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rbpi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rbpi_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rbpi_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   op_type                 op;
   seq_flags_type          seq_flags;
   dp_flags_type           dp_flags;
   logic                   load_en;
   logic                   emit_en;
   logic                   out_full;
   logic [BW_W-1:0]        bandwidth;
   clamp_type              clamp_status;

   assign csr_ready  = 1'b1;
   assign req_tready = (op == OP_LOAD);
   assign load_en    = req_tvalid && req_tready;
   assign out_full   = rsp_tvalid_ff && !rsp_tready;
   assign emit_en    = (op == OP_EMIT) && !out_full;

   assign seq_flags.no_req   = !req_tvalid;
   assign seq_flags.out_full = out_full;
   assign seq_flags.dp       = dp_flags;

   rbpi_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (seq_flags),
      .op    (op)
   );

   rbpi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .load_en          (load_en),
      .emit_en          (emit_en),
      .scheduling_error (req_tdata[WORD_W-1:0]),
      .cfg              (cfg_ff),
      .bandwidth        (bandwidth),
      .clamp_status     (clamp_status),
      .flags            (dp_flags)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GAIN_A_NEG: cfg_in.gain_a_negative = WORD_W'(csr_data);
            REG_GAIN_B_NEG: cfg_in.gain_b_negative = WORD_W'(csr_data);
            REG_GAIN_A_POS: cfg_in.gain_a_positive = WORD_W'(csr_data);
            REG_GAIN_B_POS: cfg_in.gain_b_positive = WORD_W'(csr_data);
            REG_TARGET:     cfg_in.target_error    = WORD_W'(csr_data);
            REG_MAX_BW:     cfg_in.max_bandwidth   = csr_data[BW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (emit_en) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_TDATA_W'({clamp_status, bandwidth});
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{gain_a_negative: '0, gain_b_negative: '0,
                            gain_a_positive: '0, gain_b_positive: '0,
                            target_error: '0, max_bandwidth: MAX_BW_RESET};
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      load_en |-> !emit_en)
      else $error("input accepted during emit step");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      emit_en |=> rsp_tvalid)
      else $error("emitted result not presented");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");
`endif

endmodule

### bench/rbpi_checker.sv
// ----------------------------------------------------------------------------
// rbpi_checker
// Watches the sample, result and register channels of the bandwidth PI
// controller. It keeps its own copy of the gains, target, bandwidth ceiling,
// drive and last error, predicts the granted bandwidth and clamp status of
// every accepted sample, and compares each result beat in order.
// ----------------------------------------------------------------------------
module rbpi_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rbpi_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rbpi_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [rbpi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rbpi_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               outstanding,
   output int                               free_count,
   output int                               capped_count,
   output int                               floored_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rbpi_pkg::*;

   localparam longint unsigned UNITY_SQ = 64'd1 << (2 * FRAC_BITS);
   localparam longint          DRIVE_HI = 64'sd2147483647;
   localparam longint          DRIVE_LO = -64'sd2147483648;
   localparam int              PRINT_CAP = 40;

   typedef struct packed {
      logic [BW_W-1:0] bandwidth;
      clamp_type       clamp;
   } grant_type;

   logic signed [WORD_W-1:0] k_err_neg, k_prev_neg, k_err_pos, k_prev_pos, setpoint;
   logic        [BW_W-1:0]   bw_ceiling;
   logic signed [WORD_W-1:0] held_drive, held_error;
   grant_type                owed_grants[$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      free_count    = 0;
      capped_count  = 0;
      floored_count = 0;
   end

   task automatic flag(input string msg);
      if (fail_count < PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // drive recomputed from a clamped bandwidth
   function automatic logic signed [WORD_W-1:0] drive_for(input longint unsigned bw);
      longint unsigned q;
      if (bw == 0)
         return DRIVE_MAX;
      q = UNITY_SQ / bw;
      if (q > DRIVE_MAX)
         return DRIVE_MAX;
      return q[WORD_W-1:0];
   endfunction

   function automatic grant_type next_grant(input logic signed [WORD_W-1:0] err);
      longint                   k_now, k_last, dev_now, dev_last, sum;
      logic signed [WORD_W-1:0] drv;
      longint unsigned          bw;
      grant_type                g;
      if (err < 0) begin
         k_now  = k_err_neg;
         k_last = k_prev_neg;
      end else begin
         k_now  = k_err_pos;
         k_last = k_prev_pos;
      end
      dev_now  = longint'(err) - longint'(setpoint);
      dev_last = longint'(held_error) - longint'(setpoint);
      sum = longint'(held_drive) - ((k_now * dev_now) >>> FRAC_BITS)
            - ((k_last * dev_last) >>> FRAC_BITS);
      if (sum > DRIVE_HI)
         drv = DRIVE_HI[WORD_W-1:0];
      else if (sum < DRIVE_LO)
         drv = DRIVE_LO[WORD_W-1:0];
      else
         drv = sum[WORD_W-1:0];

      bw = (drv > 0) ? UNITY_SQ / longint'(drv) : 64'd0;
      g.clamp = CLAMP_NONE;
      if (drv == 0 || (drv > 0 && bw > bw_ceiling)) begin
         bw      = bw_ceiling;
         drv     = drive_for(bw);
         g.clamp = CLAMP_MAX;
      end
      if (drv < 0 || bw < MIN_BW) begin
         bw      = MIN_BW;
         drv     = drive_for(bw);
         g.clamp = CLAMP_MIN;
      end
      held_error  = err;
      held_drive  = drv;
      g.bandwidth = bw[BW_W-1:0];
      return g;
   endfunction

   always @(posedge clock) begin : watch
      grant_type want;
      logic [BW_W-1:0]    got_bw;
      logic [CLAMP_W-1:0] got_clamp;
      if (reset) begin
         k_err_neg  = '0;
         k_prev_neg = '0;
         k_err_pos  = '0;
         k_prev_pos = '0;
         setpoint   = '0;
         bw_ceiling = MAX_BW_RESET;
         held_drive = DRIVE_ONE;
         held_error = '0;
         owed_grants.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAIN_A_NEG: k_err_neg  = csr_data;
               REG_GAIN_B_NEG: k_prev_neg = csr_data;
               REG_GAIN_A_POS: k_err_pos  = csr_data;
               REG_GAIN_B_POS: k_prev_pos = csr_data;
               REG_TARGET:     setpoint   = csr_data;
               REG_MAX_BW:     bw_ceiling = csr_data[BW_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            owed_grants.push_back(next_grant(req_tdata[WORD_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got_bw    = rsp_tdata[BW_W-1:0];
            got_clamp = rsp_tdata[BW_W+CLAMP_W-1:BW_W];
            if (owed_grants.size() == 0) begin
               flag($sformatf("result beat bw=%0d status=%0d with no sample pending",
                              got_bw, got_clamp));
            end else begin
               want = owed_grants.pop_front();
               if (got_bw !== want.bandwidth)
                  flag($sformatf("bandwidth %0d, predicted %0d", got_bw, want.bandwidth));
               if (got_clamp !== want.clamp)
                  flag($sformatf("clamp status %0d, predicted %0d", got_clamp, want.clamp));
               case (want.clamp)
                  CLAMP_MAX: capped_count++;
                  CLAMP_MIN: floored_count++;
                  default:   free_count++;
               endcase
            end
            if (rsp_tdata[RSP_TDATA_W-1:BW_W+CLAMP_W] !== '0)
               flag($sformatf("pad bits of result beat not zero: %h", rsp_tdata));
         end
      end
      outstanding = owed_grants.size();
   end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the reservation bandwidth PI controller. A short
// directed part hits zero and negative drive, drive saturation, a ceiling
// below the floor and unused register indexes; then random settings and
// error samples run with random gaps, stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbpi_pkg::*;

   localparam int                     SAMPLE_GOAL = 1800;
   localparam int                     LONG_HOLD   = 400;
   localparam logic [CSR_INDEX_W-1:0] SPARE_INDEX_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] SPARE_INDEX_B = 3'd7;

   typedef enum {MODE_GENTLE, MODE_WILD, MODE_LOW_CAP, MODE_EDGE_CAP} mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int fail_count, outstanding, free_count, capped_count, floored_count;
   int samples = 0;
   int settings = 0;
   int hold_cycles = 0;
   bit quiet_req = 1'b0;
   bit quiet_rsp = 1'b0;

   always #5 clock = ~clock;

   reservation_bandwidth_pi_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rbpi_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .free_count    (free_count),
      .capped_count  (capped_count),
      .floored_count (floored_count)
   );

   task automatic send_sample(input logic [WORD_W-1:0] err);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= err;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      samples++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic configure(input cfg_type c);
      write_reg(REG_GAIN_A_NEG, c.gain_a_negative);
      write_reg(REG_GAIN_B_NEG, c.gain_b_negative);
      write_reg(REG_GAIN_A_POS, c.gain_a_positive);
      write_reg(REG_GAIN_B_POS, c.gain_b_positive);
      write_reg(REG_TARGET,     c.target_error);
      write_reg(REG_MAX_BW,     CSR_DATA_W'(c.max_bandwidth));
      csr_valid <= 1'b0;
      settings++;
   endtask

   // block is idle once every owed result is back and the settle wait has passed
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] mild_error();
      if ($urandom_range(0, 9) == 0)
         return $urandom;
      return WORD_W'(int'($urandom_range(0, 524288)) - 262144);
   endfunction

   function automatic logic [WORD_W-1:0] mild_gain();
      int g;
      g = int'($urandom_range(0, 65536));
      return WORD_W'(($urandom_range(0, 4) == 0) ? -g : g);
   endfunction

   function automatic cfg_type pick_setting(input mode_type m);
      cfg_type c;
      if (m == MODE_WILD) begin
         c.gain_a_negative = $urandom;
         c.gain_b_negative = $urandom;
         c.gain_a_positive = $urandom;
         c.gain_b_positive = $urandom;
         c.target_error    = $urandom;
         c.max_bandwidth   = BW_W'($urandom_range(0, 65536));
      end else begin
         c.gain_a_negative = mild_gain();
         c.gain_b_negative = mild_gain();
         c.gain_a_positive = mild_gain();
         c.gain_b_positive = mild_gain();
         c.target_error    = WORD_W'(int'($urandom_range(0, 262144)) - 131072);
         case (m)
            MODE_LOW_CAP:  c.max_bandwidth = BW_W'($urandom_range(0, 654));
            MODE_EDGE_CAP: c.max_bandwidth = $urandom_range(0, 1) ? MIN_BW : MAX_BW_RESET;
            default:       c.max_bandwidth = BW_W'($urandom_range(655, 65536));
         endcase
      end
      return c;
   endfunction

   initial begin : receiver
      int stall;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = quiet_rsp ? 0 : $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : watchdog
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      cfg_type  c;
      mode_type m;
      int       r, len, phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: zero gains, drive holds at 1.0
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0001);

      // unit error gain: zero drive, then negative drive, then the floor exactly
      drain(4);
      c = '{gain_a_negative: '0, gain_b_negative: '0, gain_a_positive: 32'sd65536,
            gain_b_positive: '0, target_error: '0, max_bandwidth: MAX_BW_RESET};
      configure(c);
      send_sample(32'd65536);
      send_sample(32'd131072);
      send_sample(32'd0);

      // extreme gains and target: drive saturates both ways
      drain(4);
      c = '{gain_a_negative: 32'sh7FFF_FFFF, gain_b_negative: 32'sh8000_0000,
            gain_a_positive: 32'sh8000_0000, gain_b_positive: 32'sh7FFF_FFFF,
            target_error: 32'sh8000_0000, max_bandwidth: MAX_BW_RESET};
      configure(c);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);

      // ceiling below the floor, then zero, then exactly the floor
      drain(4);
      c = '{gain_a_negative: '0, gain_b_negative: '0, gain_a_positive: '0,
            gain_b_positive: '0, target_error: '0, max_bandwidth: 17'd300};
      configure(c);
      send_sample(32'h1234_5678);
      send_sample(32'h0000_0000);
      drain(4);
      write_reg(REG_MAX_BW, '0);
      csr_valid <= 1'b0;
      send_sample(32'h0000_0005);
      drain(4);
      write_reg(REG_MAX_BW, CSR_DATA_W'(MIN_BW));
      csr_valid <= 1'b0;
      send_sample(32'hFFFF_0000);

      // writes to unused indexes change nothing
      drain(4);
      write_reg(SPARE_INDEX_A, 32'hFFFF_FFFF);
      write_reg(SPARE_INDEX_B, 32'h0000_0000);
      csr_valid <= 1'b0;
      send_sample(32'h0001_0000);

      phase = 0;
      while (samples < SAMPLE_GOAL) begin
         drain(4);
         r = $urandom_range(0, 9);
         m = (r <= 5) ? MODE_GENTLE : (r <= 7) ? MODE_WILD : (r == 8) ? MODE_LOW_CAP
             : MODE_EDGE_CAP;
         if (phase == 0)
            m = MODE_GENTLE;
         configure(pick_setting(m));
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            quiet_req   = 1'b1;
            hold_cycles = LONG_HOLD;
         end
         len = $urandom_range(40, 200);
         repeat (len)
            send_sample((m == MODE_WILD) ? $urandom : mild_error());
         phase++;
      end

      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
      drain(100);
      $display("Ran %0d samples over %0d register settings with random gaps and stalls.",
               samples, settings);
      $display("Results: %0d within range, %0d held at the ceiling, %0d held at the floor.",
               free_count, capped_count, floored_count);
      if (fail_count == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
